/* rtl/integer_square_root_32_top_defines.svh */
// assertion macros for the square root pipeline
`ifndef INTEGER_SQUARE_ROOT_32_TOP_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_32_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define ISQRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define ISQRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define ISQRT_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/isqrt_pkg.sv */
package isqrt_pkg;

  localparam int unsigned Rounds = 16;
  localparam logic [31:0] FirstBit = 32'h4000_0000;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] root;
  } work_t;

  // test bit used by a given round
  function automatic logic [31:0] round_bit(input int unsigned round);
    return FirstBit >> (2 * round);
  endfunction

endpackage

/* rtl/isqrt_in_if.sv */
interface isqrt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] radicand;

  modport source(output valid, output radicand, input ready);
  modport sink(input valid, input radicand, output ready);
endinterface

/* rtl/isqrt_out_if.sv */
interface isqrt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] root;

  modport source(output valid, output root, input ready);
  modport sink(input valid, input root, output ready);
endinterface

/* rtl/isqrt_stage.sv */
module isqrt_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        test_bit,
  input  logic               in_valid,
  output logic               in_ready,
  input  isqrt_pkg::work_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output isqrt_pkg::work_t   out_data
);

  logic [32:0]      trial;
  isqrt_pkg::work_t data_next;

  always_comb begin
    trial = {1'b0, in_data.root} + {1'b0, test_bit};
    if ({1'b0, in_data.rem} >= trial) begin
      data_next.rem  = in_data.rem - trial[31:0];
      data_next.root = (in_data.root >> 1) + test_bit;
    end else begin
      data_next.rem  = in_data.rem;
      data_next.root = in_data.root >> 1;
    end
  end

  // slot frees when empty or when its contents move on
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/integer_square_root_32_top.sv */
// floor square root of a 32-bit radicand, one round of the digit method per stage
// a request is registered in each stage in turn before its result is offered
// throughput: one request per cycle without stalls, set by the 16 single-round stages
// a stalled result holds the full stages behind it; nothing is dropped or repeated
// reset (synchronous) empties every stage; no other state is kept
`include "integer_square_root_32_top_defines.svh"

module integer_square_root_32_top (
  input  logic         clk,
  input  logic         rst,
  isqrt_in_if.sink     req,
  isqrt_out_if.source  rsp
);

  logic             valid [isqrt_pkg::Rounds+1];
  logic             ready [isqrt_pkg::Rounds+1];
  isqrt_pkg::work_t data  [isqrt_pkg::Rounds+1];

  assign valid[0]     = req.valid;
  assign req.ready    = ready[0];
  assign data[0].rem  = req.radicand;
  assign data[0].root = '0;

  for (genvar k = 0; k < isqrt_pkg::Rounds; k++) begin : g_round
    isqrt_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .test_bit  (isqrt_pkg::round_bit(k)),
      .in_valid  (valid[k]),
      .in_ready  (ready[k]),
      .in_data   (data[k]),
      .out_valid (valid[k+1]),
      .out_ready (ready[k+1]),
      .out_data  (data[k+1])
    );
  end

  assign ready[isqrt_pkg::Rounds] = rsp.ready;
  assign rsp.valid = valid[isqrt_pkg::Rounds];
  assign rsp.root  = data[isqrt_pkg::Rounds].root[15:0];

  `ISQRT_ASSERT_IMP(a_stall_only_from_output, !req.ready, rsp.valid && !rsp.ready, "input blocked without an output stall")
  `ISQRT_ASSERT_NEXT(a_request_enters_pipe, req.valid && req.ready, valid[1], "accepted request missing from first stage")
  `ISQRT_ASSERT_NEXT_ALWAYS(a_reset_empties_pipe, rst, !rsp.valid, "result valid straight after reset")

endmodule

/* verif/isqrt_checker.sv */
module isqrt_checker (
  input  logic        clk,
  input  logic        rst,
  isqrt_in_if         req,
  isqrt_out_if        rsp,
  output int unsigned failures,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RootBits = 16;
  localparam logic [32:0] TopProbe = 33'h0_4000_0000;

  logic [15:0] expected_roots[$];

  // digit-by-digit floor square root, partial root seeded with zero
  function automatic logic [15:0] floor_sqrt(input logic [31:0] value);
    logic [32:0] remainder;
    logic [32:0] partial;
    logic [32:0] probe;
    logic [32:0] trial;
    remainder = {1'b0, value};
    partial = '0;
    probe = TopProbe;
    for (int step = 0; step < RootBits; step++) begin
      trial = partial + probe;
      if (remainder >= trial) begin
        remainder = remainder - trial;
        partial = (partial >> 1) + probe;
      end else begin
        partial = partial >> 1;
      end
      probe = probe >> 2;
    end
    return partial[15:0];
  endfunction

  initial failures = 0;

  assign pending = expected_roots.size();

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        expected_roots.push_back(floor_sqrt(req.radicand));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: result with no request outstanding: expected none, actual root %0d",
                   $time, rsp.root);
          failures = failures + 1;
        end else begin
          want = expected_roots.pop_front();
          if (rsp.root !== want) begin
            $display("%0t: root mismatch: expected %0d, actual %0d", $time, want, rsp.root);
            failures = failures + 1;
          end
        end
      end
    end
  end

endmodule

/* verif/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomCount = 1430;
  localparam int unsigned HoldAfter = 400;
  localparam int unsigned HoldCycles = 80;

  logic        clk;
  logic        rst;
  int unsigned failures;
  int unsigned pending;
  bit          tx_steady;
  bit          rx_steady;

  isqrt_in_if  req_ch ();
  isqrt_out_if rsp_ch ();

  integer_square_root_32_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  isqrt_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .failures (failures),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offers one request and returns at the falling edge after it is taken
  task automatic send_radicand(input logic [31:0] value);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.radicand <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mixes uniform values, near-square values and small values
  function automatic logic [31:0] random_radicand();
    logic [31:0] base;
    logic [15:0] side;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    base = $urandom;
    side = 16'($urandom);
    if (pick < 4) begin
      return base;
    end else if (pick < 7) begin
      return (side * side) + $urandom_range(0, 2) - 1;
    end else begin
      return base >> $urandom_range(1, 31);
    end
  endfunction

  initial begin
    logic [31:0] directed[$];
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.radicand = '0;
    tx_steady = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    directed = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h8, 32'h9,
                 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFE_0001, 32'hFFFE_0000,
                 32'h4000_0000, 32'h3FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, 32'h0000_FFFF,
                 32'hFFFF_0000, 32'h0000_0100};
    foreach (directed[i]) send_radicand(directed[i]);

    for (int n = 0; n < RandomCount; n++) begin
      if (n % 100 == 0) tx_steady = ($urandom_range(0, 2) == 0);
      send_radicand(random_radicand());
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off so the pipeline backs up
  initial begin
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    rsp_ch.ready = 1'b0;
    rx_steady = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 100 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 4);
      if (taken == HoldAfter) stall = HoldCycles;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      taken = taken + 1;
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/isqrt_pkg.sv
rtl/isqrt_in_if.sv
rtl/isqrt_out_if.sv
rtl/isqrt_stage.sv
rtl/integer_square_root_32_top.sv
verif/isqrt_checker.sv
verif/testbench.sv
